@@ sv/mvmu_pkg.sv @@
// ----------------------------------------------------------------------------
// mvmu_pkg
// Shared types, constants and saturating helpers for the matrix-vector
// multiply-update block.
// ----------------------------------------------------------------------------
package mvmu_pkg;

  localparam int DATA_W      = 32;
  localparam int ACC_W       = 64;
  localparam int STORE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int MAX_COLS    = 256;
  localparam int COL_TOP     = (MAX_COLS < STORE_DEPTH) ? MAX_COLS : STORE_DEPTH;
  localparam int COL_W       = 9;
  localparam int ROW_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int FRAC_W      = 16;

  localparam logic signed [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 2'd0,
    CFG_BETA  = 2'd1,
    CFG_COLS  = 2'd2,
    CFG_ROWS  = 2'd3
  } cfg_idx_t;

  // Write request into the vector store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } store_wr_t;

  // Step strobes from the sequencer to the datapath
  typedef struct packed {
    logic load_in;
    logic mul_x;
    logic acc;
    logic sum16;
    logic mul_a;
    logic mul_b;
    logic add_t;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic                     clip;
    logic signed [ACC_W-1:0]  val;
  } sat64_t;

  typedef struct packed {
    logic                     clip;
    logic signed [DATA_W-1:0] val;
  } sat32_t;

  function automatic sat64_t sat_add64(input logic signed [ACC_W-1:0] a,
                                       input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    sat64_t                r;
    s      = (ACC_W+1)'(a) + (ACC_W+1)'(b);
    r.clip = (s[ACC_W] != s[ACC_W-1]);
    if (r.clip) begin
      r.val = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      r.val = s[ACC_W-1:0];
    end
    return r;
  endfunction

  // Floor shift from Q32.32 to Q16.16, then clip to 32 bits
  function automatic sat32_t sat_shift32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] sh;
    sat32_t                  r;
    sh     = v >>> FRAC_W;
    r.clip = !((&sh[ACC_W-1:DATA_W-1]) || !(|sh[ACC_W-1:DATA_W-1]));
    if (r.clip) begin
      r.val = sh[ACC_W-1] ? DATA_MIN : DATA_MAX;
    end else begin
      r.val = sh[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/mvmu_store.sv @@
// ----------------------------------------------------------------------------
// mvmu_store
// Vector entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mvmu_store (
  input  logic                                clk,
  input  mvmu_pkg::store_wr_t                 wr,
  input  logic                                rd_en,
  input  logic [mvmu_pkg::ADDR_W-1:0]         rd_addr,
  output logic [mvmu_pkg::DATA_W-1:0]         rd_data
);
  import mvmu_pkg::*;

  logic [DATA_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/mvmu_datapath.sv @@
// ----------------------------------------------------------------------------
// mvmu_datapath
// Shared multiplier, saturating row accumulator and the alpha/beta update.
// ----------------------------------------------------------------------------
module mvmu_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  mvmu_pkg::ctrl_t                    ctrl,
  input  logic signed [mvmu_pkg::DATA_W-1:0] in_value,
  input  logic signed [mvmu_pkg::DATA_W-1:0] in_y_old,
  input  logic signed [mvmu_pkg::DATA_W-1:0] alpha,
  input  logic signed [mvmu_pkg::DATA_W-1:0] beta,
  input  logic        [mvmu_pkg::DATA_W-1:0] x_rd,
  output logic signed [mvmu_pkg::DATA_W-1:0] y_res,
  output logic                               sat_res
);
  import mvmu_pkg::*;

  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] yold_r;
  logic signed [DATA_W-1:0] sum16;
  logic signed [ACC_W-1:0]  prod;
  logic signed [ACC_W-1:0]  tacc;
  logic signed [ACC_W-1:0]  row_sum;
  logic                     row_clip;

  logic signed [DATA_W-1:0] op_a;
  logic signed [DATA_W-1:0] op_b;
  sat64_t                   acc_sat;
  sat64_t                   t_sat;
  sat32_t                   s16_sat;
  sat32_t                   y_sat;

  // One multiplier, operands picked by the current step
  always_comb begin
    priority if (ctrl.mul_a) begin
      op_a = alpha;
      op_b = sum16;
    end else if (ctrl.mul_b) begin
      op_a = beta;
      op_b = yold_r;
    end else begin
      op_a = value_r;
      op_b = x_rd;
    end
  end

  assign acc_sat = sat_add64(row_sum, prod);
  assign t_sat   = sat_add64(tacc, prod);
  assign s16_sat = sat_shift32(row_sum);
  assign y_sat   = sat_shift32(tacc);

  assign y_res   = y_sat.val;
  assign sat_res = row_clip | y_sat.clip;

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      value_r <= in_value;
      yold_r  <= in_y_old;
    end
    if (ctrl.mul_x || ctrl.mul_a || ctrl.mul_b) begin
      prod <= ACC_W'(op_a) * ACC_W'(op_b);
    end
    if (ctrl.sum16) begin
      sum16 <= s16_sat.val;
    end
    // Keep alpha*sum while the beta product is formed
    if (ctrl.mul_b) begin
      tacc <= prod;
    end else if (ctrl.add_t) begin
      tacc <= t_sat.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum  <= '0;
      row_clip <= 1'b0;
    end else if (ctrl.finish) begin
      row_sum  <= '0;
      row_clip <= 1'b0;
    end else begin
      if (ctrl.acc) begin
        row_sum <= acc_sat.val;
      end
      if ((ctrl.acc && acc_sat.clip) || (ctrl.sum16 && s16_sat.clip) ||
          (ctrl.add_t && t_sat.clip)) begin
        row_clip <= 1'b1;
      end
    end
  end

endmodule

@@ sv/matrix_vector_multiply_update.sv @@
// ----------------------------------------------------------------------------
// matrix_vector_multiply_update
// y = alpha*A*x + beta*y in signed Q16.16, with a saturating Q32.32 row sum.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    req_type, entry_index, value, y_old
//   out      source     out_valid / out_ready  y_new, row_index, saturated
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load item is written to the store as it is taken. A matrix item passes
// through the steps store read, multiply and accumulate. The last column of a
// row adds the steps shift, alpha product, beta product, add and result; both
// products use the one shared multiplier. A finished row waits while the
// output register is full, and no item is taken meanwhile; items flow again
// once the result has moved into the output register.
// Reset (rst, synchronous) clears counters, row sum and out_valid; the vector
// store has no reset. cfg_ready is always high.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_update (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 req_type,
  input  logic [7:0]                           entry_index,
  input  logic signed [mvmu_pkg::DATA_W-1:0]   value,
  input  logic signed [mvmu_pkg::DATA_W-1:0]   y_old,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mvmu_pkg::DATA_W-1:0]   y_new,
  output logic [mvmu_pkg::ROW_W-1:0]           row_index,
  output logic                                 saturated,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mvmu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mvmu_pkg::DATA_W-1:0]          cfg_data
);
  import mvmu_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_ACC  = 8'b0000_0100,
    S_SUM  = 8'b0000_1000,
    S_MULA = 8'b0001_0000,
    S_MULB = 8'b0010_0000,
    S_ADD  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t                   state;
  state_t                   state_next;
  ctrl_t                    ctrl;

  logic signed [DATA_W-1:0] alpha_gain;
  logic signed [DATA_W-1:0] beta_gain;
  logic [COL_W-1:0]         cols_in_use;
  logic [ROW_W-1:0]         rows_in_use;

  logic [ADDR_W-1:0]        column_count;
  logic [ADDR_W-1:0]        column_count_next;
  logic [ROW_W-1:0]         row_count;
  logic [ROW_W-1:0]         row_count_next;

  logic                     in_fire;
  logic                     out_free;
  logic                     last_col;
  logic [COL_W-1:0]         ncols;
  logic [ROW_W-1:0]         nrows;
  store_wr_t                st_wr;
  logic [DATA_W-1:0]        x_rd;
  logic signed [DATA_W-1:0] y_res;
  logic                     sat_res;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain  <= DATA_W'(32'sd65536);
      beta_gain   <= '0;
      cols_in_use <= COL_W'(256);
      rows_in_use <= ROW_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ALPHA: alpha_gain  <= cfg_data;
        CFG_BETA:  beta_gain   <= cfg_data;
        CFG_COLS:  cols_in_use <= cfg_data[COL_W-1:0];
        CFG_ROWS:  rows_in_use <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp column count to 1..COL_TOP, row count to at least 1
  always_comb begin
    priority if (cols_in_use == '0) begin
      ncols = COL_W'(1);
    end else if (cols_in_use > COL_W'(COL_TOP)) begin
      ncols = COL_W'(COL_TOP);
    end else begin
      ncols = cols_in_use;
    end
    nrows = (rows_in_use == '0) ? ROW_W'(1) : rows_in_use;
  end

  assign last_col = ((COL_W+1)'(column_count) + (COL_W+1)'(1)) >= (COL_W+1)'(ncols);
  assign column_count_next = last_col ? '0 : column_count + ADDR_W'(1);
  assign row_count_next = (((ROW_W+1)'(row_count) + (ROW_W+1)'(1)) >= (ROW_W+1)'(nrows))
                          ? '0 : row_count + ROW_W'(1);

  assign st_wr.en   = in_fire && !req_type;
  assign st_wr.addr = entry_index[ADDR_W-1:0];
  assign st_wr.data = value;

  mvmu_store u_store (
    .clk     (clk),
    .wr      (st_wr),
    .rd_en   (in_fire && req_type),
    .rd_addr (column_count),
    .rd_data (x_rd)
  );

  mvmu_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .in_value (value),
    .in_y_old (y_old),
    .alpha    (alpha_gain),
    .beta     (beta_gain),
    .x_rd     (x_rd),
    .y_res    (y_res),
    .sat_res  (sat_res)
  );

  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire && req_type) begin
          ctrl.load_in = 1'b1;
          state_next   = S_MUL;
        end
      end
      S_MUL: begin
        ctrl.mul_x = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        ctrl.acc   = 1'b1;
        state_next = last_col ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        ctrl.sum16 = 1'b1;
        state_next = S_MULA;
      end
      S_MULA: begin
        ctrl.mul_a = 1'b1;
        state_next = S_MULB;
      end
      S_MULB: begin
        ctrl.mul_b = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        ctrl.add_t = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // Hold the row result until the output register frees up
        if (out_free) begin
          ctrl.finish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      column_count <= '0;
      row_count    <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.acc) begin
        column_count <= column_count_next;
      end
      if (ctrl.finish) begin
        row_count <= row_count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      y_new     <= y_res;
      row_index <= row_count;
      saturated <= sat_res;
    end
  end

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised without a finished row");

  a_acc_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |=> (state == S_IDLE || state == S_SUM))
    else $error("accumulate step left to a wrong state");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !out_ready) |=> (state == S_OUT))
    else $error("row result dropped while output was full");

  a_col_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && last_col) |=> (column_count == '0))
    else $error("column counter not cleared at row end");

endmodule

@@ verif/matrix_vector_multiply_update_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_vector_multiply_update_tb
// Streams vector loads and matrix elements into the multiply-update block and
// checks every finished row against a cycle-free predictor of y = alpha*A*x +
// beta*y in Q16.16. A short table of hand-picked items comes first, then
// random phases with fresh register settings and random idling on both
// channels.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_update_tb;
  import mvmu_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RAND_ITEMS    = 700;
  localparam int CALM_ITEMS    = 600;
  localparam logic [DATA_W-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [DATA_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] y;
    logic [ROW_W-1:0]         row;
    logic                     sat;
  } row_result_t;

  typedef struct {
    logic              is_cfg;
    cfg_idx_t          reg_sel;
    logic [DATA_W-1:0] reg_data;
    logic              rtype;
    logic [7:0]        idx;
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] yold;
    logic              typed;
    row_result_t       res;
  } dir_step_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic                     req_type;
  logic [7:0]               entry_index;
  logic signed [DATA_W-1:0] value;
  logic signed [DATA_W-1:0] y_old;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] y_new;
  logic [ROW_W-1:0]         row_index;
  logic                     saturated;
  logic                     cfg_valid;
  logic                     cfg_ready;
  cfg_idx_t                 cfg_index;
  logic [DATA_W-1:0]        cfg_data;

  // predictor copy of registers and row state
  logic signed [DATA_W-1:0] alpha_q;
  logic signed [DATA_W-1:0] beta_q;
  logic [COL_W-1:0]         cols_q;
  logic [ROW_W-1:0]         rows_q;
  logic signed [DATA_W-1:0] x_store [STORE_DEPTH];
  bit                       x_loaded [STORE_DEPTH];
  longint                   acc_q;
  logic [7:0]               col_q;
  logic [ROW_W-1:0]         row_q;
  logic                     clip_q;

  row_result_t row_results_q [$];
  row_result_t want_r;
  dir_step_t   dir_tab [$];
  int          mismatches;
  int          cycle_cnt;
  int          items_sent;
  int          gap_pct;
  int          stall_pct;
  bit          calm;

  matrix_vector_multiply_update u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .entry_index (entry_index),
    .value       (value),
    .y_old       (y_old),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .y_new       (y_new),
    .row_index   (row_index),
    .saturated   (saturated),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint add_clip(input longint a, input longint b, inout logic clip);
    if (b > 0 && a > ACC_MAX - b) begin
      clip = 1'b1;
      return ACC_MAX;
    end
    if (b < 0 && a < ACC_MIN - b) begin
      clip = 1'b1;
      return ACC_MIN;
    end
    return a + b;
  endfunction

  function automatic longint clip32(input longint v, inout logic clip);
    if (v > longint'(DATA_MAX)) begin
      clip = 1'b1;
      return longint'(DATA_MAX);
    end
    if (v < longint'(DATA_MIN)) begin
      clip = 1'b1;
      return longint'(DATA_MIN);
    end
    return v;
  endfunction

  function automatic int eff_cols();
    if (cols_q == '0) return 1;
    if (int'(cols_q) > COL_TOP) return COL_TOP;
    return int'(cols_q);
  endfunction

  // Advance the row state by one item; fired is set on a row end
  task automatic mvm_step(input logic rt, input logic [7:0] idx,
                          input logic signed [DATA_W-1:0] val,
                          input logic signed [DATA_W-1:0] yo,
                          output logic fired, output row_result_t res);
    longint prod;
    longint sum16;
    longint t;
    int     nrows;
    logic   clip;
    fired = 1'b0;
    res   = '0;
    if (rt == 1'b0) begin
      x_store[idx]  = val;
      x_loaded[idx] = 1'b1;
    end else begin
      prod  = longint'(val) * longint'(x_store[col_q]);
      acc_q = add_clip(acc_q, prod, clip_q);
      if (int'(col_q) + 1 < eff_cols()) begin
        col_q = col_q + 8'd1;
      end else begin
        clip    = clip_q;
        sum16   = clip32(acc_q >>> FRAC_W, clip);
        t       = add_clip(longint'(alpha_q) * sum16, longint'(beta_q) * longint'(yo), clip);
        res.y   = DATA_W'(clip32(t >>> FRAC_W, clip));
        res.row = row_q;
        res.sat = clip;
        fired   = 1'b1;
        nrows   = (rows_q == '0) ? 1 : int'(rows_q);
        row_q   = (int'(row_q) + 1 >= nrows) ? '0 : row_q + 1'b1;
        acc_q   = 0;
        col_q   = '0;
        clip_q  = 1'b0;
      end
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_q();
    case ($urandom_range(0, 9))
      0: return DATA_MIN;
      1: return DATA_MAX;
      2: return '0;
      3, 4, 5: return DATA_W'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return DATA_MIN;
      1: return DATA_MAX;
      2: return '0;
      3: return Q_ONE;
      4: return Q_NEG_ONE;
      5, 6: return DATA_W'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic dir_step_t item_row(input logic rt, input logic [7:0] idx,
                                         input logic [DATA_W-1:0] val,
                                         input logic [DATA_W-1:0] yo);
    dir_step_t s;
    s.is_cfg   = 1'b0;
    s.reg_sel  = CFG_ALPHA;
    s.reg_data = '0;
    s.rtype    = rt;
    s.idx      = idx;
    s.val      = val;
    s.yold     = yo;
    s.typed    = 1'b0;
    s.res      = '0;
    return s;
  endfunction

  function automatic dir_step_t cfg_row(input cfg_idx_t sel, input logic [DATA_W-1:0] d);
    dir_step_t s;
    s          = item_row(1'b0, '0, '0, '0);
    s.is_cfg   = 1'b1;
    s.reg_sel  = sel;
    s.reg_data = d;
    return s;
  endfunction

  // Matrix item that ends a row, with its result written out by hand
  function automatic dir_step_t checked_row(input logic [DATA_W-1:0] val,
                                            input logic [DATA_W-1:0] yo,
                                            input logic [DATA_W-1:0] ey,
                                            input logic [ROW_W-1:0] erow,
                                            input logic esat);
    dir_step_t s;
    s         = item_row(1'b1, 8'h3C, val, yo);
    s.typed   = 1'b1;
    s.res.y   = ey;
    s.res.row = erow;
    s.res.sat = esat;
    return s;
  endfunction

  task automatic send_item(input logic rt, input logic [7:0] idx,
                           input logic [DATA_W-1:0] val, input logic [DATA_W-1:0] yo,
                           input logic typed, input row_result_t typed_res);
    logic        fired;
    row_result_t res;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid    = 1'b1;
    req_type    = rt;
    entry_index = idx;
    value       = val;
    y_old       = yo;
    do @(posedge clk); while (!in_ready);
    mvm_step(rt, idx, val, yo, fired, res);
    if (fired) row_results_q.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  task automatic cfg_write(input cfg_idx_t sel, input logic [DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = sel;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    case (sel)
      CFG_ALPHA: alpha_q = d;
      CFG_BETA:  beta_q  = d;
      CFG_COLS:  cols_q  = d[COL_W-1:0];
      CFG_ROWS:  rows_q  = d[ROW_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drop valid, drain every pending row, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (row_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_ready = 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_ready = 1'b0;
        hold      = $urandom_range(1, 9) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (row_results_q.size() == 0) begin
        $display("%0t: unexpected row, expected none, actual y_new %h row %0d sat %b",
                 $time, y_new, row_index, saturated);
        mismatches++;
      end else begin
        want_r = row_results_q.pop_front();
        if (y_new !== want_r.y) begin
          $display("%0t: y_new mismatch, expected %h, actual %h", $time, want_r.y, y_new);
          mismatches++;
        end
        if (row_index !== want_r.row) begin
          $display("%0t: row_index mismatch, expected %0d, actual %0d",
                   $time, want_r.row, row_index);
          mismatches++;
        end
        if (saturated !== want_r.sat) begin
          $display("%0t: saturated mismatch, expected %b, actual %b",
                   $time, want_r.sat, saturated);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int               rand_base;
    int               n_mat;
    logic [3:0]       sel;
    logic [DATA_W-1:0] d;
    bit               wide_done;
    rst         = 1'b1;
    in_valid    = 1'b0;
    req_type    = 1'b0;
    entry_index = '0;
    value       = '0;
    y_old       = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_ALPHA;
    cfg_data    = '0;
    mismatches  = 0;
    cycle_cnt   = 0;
    items_sent  = 0;
    gap_pct     = 30;
    stall_pct   = 30;
    calm        = 1'b0;
    wide_done   = 1'b0;
    alpha_q     = Q_ONE;
    beta_q      = '0;
    cols_q      = 9'd256;
    rows_q      = 16'd1;
    acc_q       = 0;
    col_q       = '0;
    row_q       = '0;
    clip_q      = 1'b0;

    dir_tab.push_back(cfg_row(CFG_COLS, 32'd2));
    dir_tab.push_back(cfg_row(CFG_ROWS, 32'd3));
    dir_tab.push_back(item_row(1'b0, 8'd0, Q_ONE, '0));
    dir_tab.push_back(item_row(1'b0, 8'd1, 32'h0002_0000, '0));
    dir_tab.push_back(item_row(1'b1, 8'hFF, 32'h0003_0000, '0));
    dir_tab.push_back(checked_row(Q_ONE, DATA_MAX, 32'h0005_0000, 16'd0, 1'b0));
    // row sum beyond the Q16.16 range, both signs
    dir_tab.push_back(item_row(1'b1, 8'h00, DATA_MAX, '0));
    dir_tab.push_back(checked_row(DATA_MAX, '0, DATA_MAX, 16'd1, 1'b1));
    dir_tab.push_back(item_row(1'b1, 8'h55, DATA_MIN, DATA_MIN));
    dir_tab.push_back(checked_row(DATA_MIN, DATA_MIN, DATA_MIN, 16'd2, 1'b1));
    // accumulator hits the 64-bit ceiling
    dir_tab.push_back(item_row(1'b0, 8'd0, DATA_MIN, '0));
    dir_tab.push_back(item_row(1'b0, 8'd1, DATA_MIN, '0));
    dir_tab.push_back(item_row(1'b1, 8'hAA, DATA_MIN, DATA_MAX));
    dir_tab.push_back(checked_row(DATA_MIN, DATA_MAX, DATA_MAX, 16'd0, 1'b1));
    // alpha and beta terms overflow the final 64-bit sum
    dir_tab.push_back(cfg_row(CFG_ALPHA, DATA_MIN));
    dir_tab.push_back(cfg_row(CFG_BETA, DATA_MIN));
    dir_tab.push_back(item_row(1'b1, 8'h00, DATA_MAX, '0));
    dir_tab.push_back(checked_row(DATA_MAX, DATA_MIN, DATA_MAX, 16'd1, 1'b1));
    // negative results round toward minus infinity
    dir_tab.push_back(cfg_row(CFG_ALPHA, Q_ONE));
    dir_tab.push_back(cfg_row(CFG_BETA, 32'h0000_8000));
    dir_tab.push_back(item_row(1'b0, 8'd0, 32'hFFFF_FFFF, '0));
    dir_tab.push_back(item_row(1'b0, 8'd1, '0, '0));
    dir_tab.push_back(item_row(1'b1, 8'h01, 32'h0000_8000, '0));
    dir_tab.push_back(checked_row(32'h1234_5678, 32'h0000_0001, 32'hFFFF_FFFF, 16'd2, 1'b0));
    // column count lowered while a row is open: next item closes it
    dir_tab.push_back(item_row(1'b0, 8'd2, Q_ONE, '0));
    dir_tab.push_back(cfg_row(CFG_COLS, 32'd3));
    dir_tab.push_back(item_row(1'b1, 8'h00, Q_ONE, '0));
    dir_tab.push_back(item_row(1'b1, 8'h00, 32'h0002_0000, '0));
    dir_tab.push_back(cfg_row(CFG_COLS, 32'd2));
    dir_tab.push_back(item_row(1'b1, 8'h80, 32'hFFFE_0000, 32'h0004_0000));
    // zero column and row counts act as one
    dir_tab.push_back(cfg_row(CFG_COLS, 32'd0));
    dir_tab.push_back(cfg_row(CFG_ROWS, 32'd0));
    dir_tab.push_back(item_row(1'b1, 8'h00, DATA_MAX, DATA_MAX));
    dir_tab.push_back(item_row(1'b1, 8'h00, DATA_MIN, DATA_MIN));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        settle();
        cfg_write(dir_tab[i].reg_sel, dir_tab[i].reg_data);
      end else begin
        send_item(dir_tab[i].rtype, dir_tab[i].idx, dir_tab[i].val, dir_tab[i].yold,
                  dir_tab[i].typed, dir_tab[i].res);
      end
    end

    rand_base = items_sent;
    while (items_sent - rand_base < RAND_ITEMS) begin
      settle();
      sel = 4'($urandom_range(1, 15));
      // one wide phase only; leave it as soon as it is over
      if (eff_cols() > 24 || (!wide_done && items_sent - rand_base > 100)) sel[2] = 1'b1;
      if (sel[0]) cfg_write(CFG_ALPHA, pick_gain());
      if (sel[1]) cfg_write(CFG_BETA, pick_gain());
      if (sel[2]) begin
        d = $urandom();
        if (!wide_done && (items_sent - rand_base > 100 || $urandom_range(0, 9) == 0)) begin
          d[8:0]    = $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(257, 511));
          wide_done = 1'b1;
        end else begin
          case ($urandom_range(0, 9))
            0: d[8:0] = '0;
            1: d[8:0] = 9'd1;
            2: d[8:0] = 9'($urandom_range(9, 24));
            default: d[8:0] = 9'($urandom_range(1, 8));
          endcase
        end
        cfg_write(CFG_COLS, d);
      end
      if (sel[3]) begin
        d = $urandom();
        case ($urandom_range(0, 9))
          0: d[15:0] = '0;
          1: d[15:0] = 16'hFFFF;
          2: d[15:0] = 16'($urandom_range(0, 65535));
          default: d[15:0] = 16'($urandom_range(1, 5));
        endcase
        cfg_write(CFG_ROWS, d);
      end

      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 15;
        default: stall_pct = 40;
      endcase

      n_mat = (eff_cols() > 24) ? eff_cols() :
              eff_cols() * $urandom_range(2, 5) + $urandom_range(0, 1);
      while (n_mat > 0) begin
        calm = (items_sent - rand_base >= CALM_ITEMS);
        if (eff_cols() <= 24 && $urandom_range(0, 99) < 12) begin
          send_item(1'b0, 8'($urandom_range(0, 255)), pick_q(), $urandom(), 1'b0, '0);
        end else if (!x_loaded[col_q]) begin
          // never let a matrix item read an entry that was not loaded
          send_item(1'b0, col_q, pick_q(), $urandom(), 1'b0, '0);
        end else begin
          send_item(1'b1, 8'($urandom_range(0, 255)), pick_q(), pick_q(), 1'b0, '0);
          n_mat--;
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/mvmu_pkg.sv
sv/mvmu_store.sv
sv/mvmu_datapath.sv
sv/matrix_vector_multiply_update.sv
verif/matrix_vector_multiply_update_tb.sv
